// ----- sv/alle_pkg.sv -----
package alle_pkg;

  // node pool geometry
  localparam int PoolNodes = 16;
  localparam int AddrW     = (PoolNodes > 1) ? $clog2(PoolNodes) : 1;
  localparam int IdxW      = $clog2(PoolNodes + 1);
  localparam int ValW      = 32;

  // stream widths
  localparam int InFieldW   = 2 * ValW;
  localparam int InTdataW   = ((InFieldW + 7) / 8) * 8;
  localparam int OutFieldW  = 2 + ValW;
  localparam int OutTdataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int ReqW       = 3;

  localparam logic [IdxW-1:0] NilIdx = IdxW'(PoolNodes);

  typedef enum logic [ReqW-1:0] {
    REQ_INS_HEAD  = 3'd0,
    REQ_INS_TAIL  = 3'd1,
    REQ_INS_AFTER = 3'd2,
    REQ_DEL_HEAD  = 3'd3,
    REQ_DEL_TAIL  = 3'd4,
    REQ_DEL_AFTER = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_TAKE,
    S_DEL,
    S_FREE,
    S_PATCH,
    S_DONE
  } state_t;

  // one read and one write per cycle on the node store
  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_val_en;
    logic             wr_link_en;
    logic [AddrW-1:0] wr_addr;
    logic [ValW-1:0]  wr_val;
    logic [IdxW-1:0]  wr_link;
  } mem_req_t;

  // any link at or above the pool size is null
  function automatic logic is_nil(logic [IdxW-1:0] x);
    return x >= NilIdx;
  endfunction

endpackage

// ----- sv/array_linked_list_engine_top.sv -----
// a request refused at once passes S_START and S_DONE before out_tvalid; head operations also
// pass S_TAKE, or S_DEL and S_FREE; tail and search operations first walk the list in S_WALK
// before their edit steps
// throughput: one request at a time; a new request is accepted only after the last one has
// reached the output register; the walk reads one node per cycle through the single read
// port of the node store, and a finished result may wait in the output register
// reset (rst_n low, synchronous): empty list, all nodes chained on the free list
module array_linked_list_engine_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [31:0] item_value, [63:32] ref_value
  input  logic [alle_pkg::InTdataW-1:0]         in_tdata,
  // [2:0] req_type
  input  logic [alle_pkg::ReqW-1:0]             in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [1:0] status, [33:2] removed_value, upper bits zero
  output logic [alle_pkg::OutTdataW-1:0]        out_tdata
);

  alle_pkg::state_t  state_r, state_nxt;
  alle_pkg::req_t    req_r, req_nxt;
  logic [alle_pkg::ValW-1:0] item_r, item_nxt;
  logic [alle_pkg::ValW-1:0] ref_r, ref_nxt;

  // list pointers
  logic [alle_pkg::IdxW-1:0] head_r, head_nxt;
  logic [alle_pkg::IdxW-1:0] free_r, free_nxt;

  // walk and edit pointers
  logic [alle_pkg::IdxW-1:0] cur_r, cur_nxt;     // node being read, or node to relink
  logic [alle_pkg::IdxW-1:0] prev_r, prev_nxt;   // predecessor during the tail delete walk
  logic [alle_pkg::IdxW-1:0] succ_r, succ_nxt;   // link value to be written
  logic [alle_pkg::IdxW-1:0] vic_r, vic_nxt;     // node being removed
  logic                      link_head_r, link_head_nxt; // edit goes to head, not a node
  logic                      patch_r, patch_nxt;         // relink cur after freeing

  alle_pkg::status_t         status_r, status_nxt;
  logic [alle_pkg::ValW-1:0] removed_r, removed_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  alle_pkg::status_t         out_status_r, out_status_nxt;
  logic [alle_pkg::ValW-1:0] out_removed_r, out_removed_nxt;

  alle_pkg::mem_req_t        mreq;
  logic [alle_pkg::ValW-1:0] rd_val;
  logic [alle_pkg::IdxW-1:0] rd_link;
  logic                      rd_match;
  logic                      rd_last;

  alle_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .mreq    (mreq),
    .rd_val  (rd_val),
    .rd_link (rd_link)
  );

  // the shared compare: one node value against the reference each walk cycle
  assign rd_match = (rd_val == ref_r);
  assign rd_last  = alle_pkg::is_nil(rd_link);

  assign in_tready  = (state_r == alle_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(alle_pkg::OutTdataW - alle_pkg::OutFieldW){1'b0}},
                       out_removed_r, out_status_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alle_pkg::S_IDLE;
      head_r      <= alle_pkg::NilIdx;
      free_r      <= '0;
      out_valid_r <= 1'b0;
      link_head_r <= 1'b0;
      patch_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      link_head_r <= link_head_nxt;
      patch_r     <= patch_nxt;
    end
  end

  // request and working payload
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    item_r        <= item_nxt;
    ref_r         <= ref_nxt;
    cur_r         <= cur_nxt;
    prev_r        <= prev_nxt;
    succ_r        <= succ_nxt;
    vic_r         <= vic_nxt;
    status_r      <= status_nxt;
    removed_r     <= removed_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    item_nxt        = item_r;
    ref_nxt         = ref_r;
    head_nxt        = head_r;
    free_nxt        = free_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    succ_nxt        = succ_r;
    vic_nxt         = vic_r;
    link_head_nxt   = link_head_r;
    patch_nxt       = patch_r;
    status_nxt      = status_r;
    removed_nxt     = removed_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_valid_nxt   = out_valid_r & ~out_tready;
    mreq            = '0;

    case (state_r)
      alle_pkg::S_IDLE: begin
        if (in_tvalid) begin
          req_nxt   = alle_pkg::req_t'(in_tuser);
          item_nxt  = in_tdata[alle_pkg::ValW-1:0];
          ref_nxt   = in_tdata[2*alle_pkg::ValW-1:alle_pkg::ValW];
          state_nxt = alle_pkg::S_START;
        end
      end

      // decide on the head and free pointers, start the first read
      alle_pkg::S_START: begin
        status_nxt    = alle_pkg::ST_OK;
        removed_nxt   = '0;
        patch_nxt     = 1'b0;
        link_head_nxt = 1'b0;
        cur_nxt       = head_r;
        prev_nxt      = alle_pkg::NilIdx;
        state_nxt     = alle_pkg::S_DONE;
        case (req_r)
          alle_pkg::REQ_INS_HEAD, alle_pkg::REQ_INS_TAIL: begin
            if (alle_pkg::is_nil(free_r)) begin
              status_nxt = alle_pkg::ST_OVERFLOW;
            end else if (req_r == alle_pkg::REQ_INS_HEAD || alle_pkg::is_nil(head_r)) begin
              // insert tail on an empty list works as insert head
              mreq.rd_en    = 1'b1;
              mreq.rd_addr  = free_r[alle_pkg::AddrW-1:0];
              succ_nxt      = head_r;
              link_head_nxt = 1'b1;
              state_nxt     = alle_pkg::S_TAKE;
            end else begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = head_r[alle_pkg::AddrW-1:0];
              state_nxt    = alle_pkg::S_WALK;
            end
          end
          alle_pkg::REQ_INS_AFTER: begin
            if (alle_pkg::is_nil(head_r)) begin
              status_nxt = alle_pkg::ST_MISSING;
            end else begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = head_r[alle_pkg::AddrW-1:0];
              state_nxt    = alle_pkg::S_WALK;
            end
          end
          alle_pkg::REQ_DEL_HEAD: begin
            if (alle_pkg::is_nil(head_r)) begin
              status_nxt = alle_pkg::ST_EMPTY;
            end else begin
              mreq.rd_en    = 1'b1;
              mreq.rd_addr  = head_r[alle_pkg::AddrW-1:0];
              vic_nxt       = head_r;
              link_head_nxt = 1'b1;
              state_nxt     = alle_pkg::S_DEL;
            end
          end
          alle_pkg::REQ_DEL_TAIL, alle_pkg::REQ_DEL_AFTER: begin
            if (alle_pkg::is_nil(head_r)) begin
              status_nxt = alle_pkg::ST_EMPTY;
            end else begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = head_r[alle_pkg::AddrW-1:0];
              state_nxt    = alle_pkg::S_WALK;
            end
          end
          default: begin
            // unknown request codes leave the list alone
          end
        endcase
      end

      // node cur_r has been read: rd_val and rd_link belong to it
      alle_pkg::S_WALK: begin
        state_nxt = alle_pkg::S_DONE;
        case (req_r)
          alle_pkg::REQ_INS_TAIL: begin
            mreq.rd_en = 1'b1;
            if (rd_last) begin
              mreq.rd_addr = free_r[alle_pkg::AddrW-1:0];
              succ_nxt     = alle_pkg::NilIdx;
              state_nxt    = alle_pkg::S_TAKE;
            end else begin
              mreq.rd_addr = rd_link[alle_pkg::AddrW-1:0];
              cur_nxt      = rd_link;
              state_nxt    = alle_pkg::S_WALK;
            end
          end
          alle_pkg::REQ_INS_AFTER: begin
            if (rd_match) begin
              if (alle_pkg::is_nil(free_r)) begin
                status_nxt = alle_pkg::ST_OVERFLOW;
              end else begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = free_r[alle_pkg::AddrW-1:0];
                succ_nxt     = rd_link;
                state_nxt    = alle_pkg::S_TAKE;
              end
            end else if (rd_last) begin
              status_nxt = alle_pkg::ST_MISSING;
            end else begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = rd_link[alle_pkg::AddrW-1:0];
              cur_nxt      = rd_link;
              state_nxt    = alle_pkg::S_WALK;
            end
          end
          alle_pkg::REQ_DEL_TAIL: begin
            if (rd_last) begin
              removed_nxt = rd_val;
              vic_nxt     = cur_r;
              state_nxt   = alle_pkg::S_FREE;
              if (alle_pkg::is_nil(prev_r)) begin
                head_nxt = alle_pkg::NilIdx;
              end else begin
                // cut the old tail off its predecessor after freeing it
                cur_nxt   = prev_r;
                succ_nxt  = alle_pkg::NilIdx;
                patch_nxt = 1'b1;
              end
            end else begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = rd_link[alle_pkg::AddrW-1:0];
              prev_nxt     = cur_r;
              cur_nxt      = rd_link;
              state_nxt    = alle_pkg::S_WALK;
            end
          end
          alle_pkg::REQ_DEL_AFTER: begin
            if (rd_match) begin
              if (rd_last) begin
                status_nxt = alle_pkg::ST_MISSING;
              end else begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = rd_link[alle_pkg::AddrW-1:0];
                vic_nxt      = rd_link;
                state_nxt    = alle_pkg::S_DEL;
              end
            end else if (rd_last) begin
              status_nxt = alle_pkg::ST_MISSING;
            end else begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = rd_link[alle_pkg::AddrW-1:0];
              cur_nxt      = rd_link;
              state_nxt    = alle_pkg::S_WALK;
            end
          end
          default: begin
          end
        endcase
      end

      // free head node has been read: its link is the new free head
      alle_pkg::S_TAKE: begin
        mreq.wr_val_en  = 1'b1;
        mreq.wr_link_en = 1'b1;
        mreq.wr_addr    = free_r[alle_pkg::AddrW-1:0];
        mreq.wr_val     = item_r;
        mreq.wr_link    = succ_r;
        free_nxt        = rd_link;
        if (link_head_r) begin
          head_nxt  = free_r;
          state_nxt = alle_pkg::S_DONE;
        end else begin
          succ_nxt  = free_r;
          state_nxt = alle_pkg::S_PATCH;
        end
      end

      // victim has been read: unlink it from its predecessor or the head
      alle_pkg::S_DEL: begin
        removed_nxt = rd_val;
        if (link_head_r) begin
          head_nxt = rd_link;
        end else begin
          mreq.wr_link_en = 1'b1;
          mreq.wr_addr    = cur_r[alle_pkg::AddrW-1:0];
          mreq.wr_link    = rd_link;
        end
        state_nxt = alle_pkg::S_FREE;
      end

      // push the victim onto the front of the free list
      alle_pkg::S_FREE: begin
        mreq.wr_link_en = 1'b1;
        mreq.wr_addr    = vic_r[alle_pkg::AddrW-1:0];
        mreq.wr_link    = free_r;
        free_nxt        = vic_r;
        state_nxt       = patch_r ? alle_pkg::S_PATCH : alle_pkg::S_DONE;
      end

      alle_pkg::S_PATCH: begin
        mreq.wr_link_en = 1'b1;
        mreq.wr_addr    = cur_r[alle_pkg::AddrW-1:0];
        mreq.wr_link    = succ_r;
        state_nxt       = alle_pkg::S_DONE;
      end

      // hand the result over once the output register is free
      alle_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_removed_nxt = removed_r;
          state_nxt       = alle_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = alle_pkg::S_IDLE;
      end
    endcase
  end

  // a new request always starts with the dispatch step
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == alle_pkg::S_START)
    else $error("request accepted without dispatch");

  // only a successful delete carries a removed value
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != alle_pkg::ST_OK |-> out_removed_r == '0)
    else $error("removed value on a failed request");

  // the list and the free list never share a first node
  a_head_free: assert property (@(posedge clk) disable iff (!rst_n)
    !alle_pkg::is_nil(head_r) && !alle_pkg::is_nil(free_r) |-> head_r != free_r)
    else $error("head and free list overlap");

  // the node store is only written by the edit steps
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.wr_val_en || mreq.wr_link_en |->
      state_r == alle_pkg::S_TAKE || state_r == alle_pkg::S_DEL ||
      state_r == alle_pkg::S_FREE || state_r == alle_pkg::S_PATCH)
    else $error("node store written outside an edit step");

endmodule

// ----- sv/alle_store.sv -----
module alle_store (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  alle_pkg::mem_req_t                     mreq,
  output logic [alle_pkg::ValW-1:0]              rd_val,
  output logic [alle_pkg::IdxW-1:0]              rd_link
);

  logic [alle_pkg::ValW-1:0]      val_mem  [alle_pkg::PoolNodes];
  logic [alle_pkg::IdxW-1:0]      link_mem [alle_pkg::PoolNodes];
  logic [alle_pkg::PoolNodes-1:0] link_ok_r;
  logic [alle_pkg::ValW-1:0]      rd_val_r;
  logic [alle_pkg::IdxW-1:0]      rd_link_r;

  always_ff @(posedge clk) begin
    if (mreq.wr_val_en) begin
      val_mem[mreq.wr_addr] <= mreq.wr_val;
    end
    if (mreq.wr_link_en) begin
      link_mem[mreq.wr_addr] <= mreq.wr_link;
    end
    if (mreq.rd_en) begin
      rd_val_r <= val_mem[mreq.rd_addr];
      // untouched entries still hold the reset chain: i links i+1
      if (link_ok_r[mreq.rd_addr]) begin
        rd_link_r <= link_mem[mreq.rd_addr];
      end else begin
        rd_link_r <= alle_pkg::IdxW'(mreq.rd_addr) + alle_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_ok_r <= '0;
    end else if (mreq.wr_link_en) begin
      link_ok_r[mreq.wr_addr] <= 1'b1;
    end
  end

  assign rd_val  = rd_val_r;
  assign rd_link = rd_link_r;

endmodule
